// ===== hdl/front_middle_back_queue_defines.svh =====
// Assertion macros shared by the queue checker.
`ifndef FRONT_MIDDLE_BACK_QUEUE_DEFINES_SVH
`define FRONT_MIDDLE_BACK_QUEUE_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define FMBQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fmbq check failed");

// Consequent must hold in the cycle after the antecedent.
`define FMBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmbq check failed");

`endif

// ===== hdl/fmbq_pkg.sv =====
// Types, constants and helpers for the front/middle/back queue.
package fmbq_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;
  localparam int OCC_W      = 5;
  localparam int ACT_W      = 3;
  localparam int POS_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT  = 3'd0,
    ACT_PUSH_MIDDLE = 3'd1,
    ACT_PUSH_BACK   = 3'd2,
    ACT_POP_FRONT   = 3'd3,
    ACT_POP_MIDDLE  = 3'd4,
    ACT_POP_BACK    = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [IN_W-1:0]  push_word;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] popped_word;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } out_item_t;

  // Decoded operation handed from the control to the cell array.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
    status_e          status;
    logic [CNT_W-1:0] count_d;
  } op_t;

  // Zero-extend the request word, then keep its low WORD_WIDTH bits.
  function automatic logic [WORD_WIDTH-1:0] to_cell(input logic [IN_W-1:0] w);
    logic [63:0] z;
    z = 64'(w);
    return z[WORD_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word and give it at output width.
  function automatic logic signed [OUT_W-1:0] widen_word(input logic [WORD_WIDTH-1:0] w);
    logic signed [63:0] ext;
    ext = 64'(signed'(w));
    return ext[OUT_W-1:0];
  endfunction

endpackage

// ===== hdl/front_middle_back_queue.sv =====
// Front/middle/back queue top level: request decode, cell row and result register.
//
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_item_i): one request per action,
//     action 0..2 pushes push_word at the front, middle or back, action 3..5
//     pops from the front, middle or back; codes 6 and 7 do nothing.
//   out channel (out_valid_o / out_ready_i / out_item_o): one result for every
//     request, in request order: popped word (zero unless a pop succeeded),
//     status (done, pop on empty, push on full) and occupancy after the action.
// Result: registered, it shows in the cycle after its request is taken.
// Throughput: one request per cycle while results drain; the cell row shifts all cells in
//   parallel and the occupancy counter updates in the same cycle.
// Stall: while a result waits on out_ready_i, in_ready_o drops only if the
//   result register cannot drain in the same cycle.
// Reset: occupancy goes to zero and the result register empties; cell
//   contents are not cleared and are never read before they are written.
module front_middle_back_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fmbq_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fmbq_pkg::out_item_t  out_item_o
);
  import fmbq_pkg::*;

  logic                  take;
  op_t                   op;
  logic [WORD_WIDTH-1:0] removed;
  logic                  out_valid_q;
  out_item_t             out_item_q, out_item_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  fmbq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .action_i (in_item_i.action),
    .op_o     (op)
  );

  fmbq_cells u_cells (
    .clk_i     (clk_i),
    .take_i    (take),
    .op_i      (op),
    .word_i    (to_cell(in_item_i.push_word)),
    .removed_o (removed)
  );

  always_comb begin
    out_item_d.popped_word = op.rem ? widen_word(removed) : '0;
    out_item_d.status      = op.status;
    out_item_d.occupancy   = OCC_W'(op.count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== hdl/fmbq_ctrl.sv =====
// Occupancy counter and action decode for the queue.
module fmbq_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic [fmbq_pkg::ACT_W-1:0]     action_i,
  output fmbq_pkg::op_t                  op_o
);
  import fmbq_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] count_m1;
  logic             is_full, is_empty;

  assign is_full  = (count_q >= CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign count_m1 = count_q - CNT_W'(1);

  always_comb begin
    op_o.ins    = 1'b0;
    op_o.rem    = 1'b0;
    op_o.pos    = '0;
    op_o.status = ST_DONE;
    case (action_i)
      ACT_PUSH_FRONT, ACT_PUSH_MIDDLE, ACT_PUSH_BACK: begin
        if (is_full) begin
          op_o.status = ST_FULL;
        end else begin
          op_o.ins = 1'b1;
          if (action_i == ACT_PUSH_MIDDLE) begin
            op_o.pos = POS_W'(count_q >> 1);
          end else if (action_i == ACT_PUSH_BACK) begin
            op_o.pos = POS_W'(count_q);
          end
        end
      end
      ACT_POP_FRONT, ACT_POP_MIDDLE, ACT_POP_BACK: begin
        if (is_empty) begin
          op_o.status = ST_EMPTY;
        end else begin
          op_o.rem = 1'b1;
          if (action_i == ACT_POP_MIDDLE) begin
            op_o.pos = POS_W'(count_m1 >> 1);
          end else if (action_i == ACT_POP_BACK) begin
            op_o.pos = POS_W'(count_m1);
          end
        end
      end
      default: ;  // unused codes leave the queue alone
    endcase

    count_d = count_q;
    if (op_o.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (op_o.rem) begin
      count_d = count_m1;
    end
    op_o.count_d = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (take_i) begin
      count_q <= count_d;
    end
  end

endmodule

// ===== hdl/fmbq_cells.sv =====
// Row of word cells that shift open or closed around one position.
module fmbq_cells (
  input  logic                            clk_i,
  input  logic                            take_i,
  input  fmbq_pkg::op_t                   op_i,
  input  logic [fmbq_pkg::WORD_WIDTH-1:0] word_i,
  output logic [fmbq_pkg::WORD_WIDTH-1:0] removed_o
);
  import fmbq_pkg::*;

  logic [WORD_WIDTH-1:0] cells_q [CAPACITY];
  logic [WORD_WIDTH-1:0] cells_d [CAPACITY];

  assign removed_o = cells_q[op_i.pos];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_d[i] = cells_q[i];
      if (op_i.ins) begin
        if (POS_W'(i) == op_i.pos) begin
          cells_d[i] = word_i;
        end else if ((i > 0) && (POS_W'(i) > op_i.pos)) begin
          cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
        end
      end else if (op_i.rem) begin
        // close the gap: cells at and past the position take their successor
        if ((i < CAPACITY - 1) && (POS_W'(i) >= op_i.pos)) begin
          cells_d[i] = cells_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

endmodule

// ===== hdl/fmbq_checker.sv =====
// Port-level checks for the queue, bound to the top level.
`include "front_middle_back_queue_defines.svh"

module fmbq_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input fmbq_pkg::out_item_t  out_item_o
);
  import fmbq_pkg::*;

  logic in_take;
  logic out_stall;
  logic empty_ok;
  logic full_ok;

  assign in_take   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign empty_ok  = !(out_valid_o && out_item_o.status == ST_EMPTY) ||
                     (out_item_o.occupancy == '0 && out_item_o.popped_word == '0);
  assign full_ok   = !(out_valid_o && out_item_o.status == ST_FULL) ||
                     (out_item_o.occupancy == OCC_W'(CAPACITY) &&
                      out_item_o.popped_word == '0);

  `FMBQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_item_o))
  `FMBQ_ASSERT_NEXT(a_take_gives_result, clk_i, rst_ni, in_take, out_valid_o)
  `FMBQ_ASSERT(a_empty_result, clk_i, rst_ni, empty_ok)
  `FMBQ_ASSERT(a_full_result, clk_i, rst_ni, full_ok)

endmodule

bind front_middle_back_queue fmbq_checker u_fmbq_checker (.*);
